// File: design/uas_pkg.sv
package uas_pkg;

  localparam int VALUE_BITS     = 16;
  localparam int FACTOR_BITS    = 16;
  localparam int LEN_BITS       = 11;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int LINE_DEPTH     = 1024;

  localparam int ROW_LENGTH_RESET  = 1024;
  localparam int INV_LENGTH_RESET  = 64;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ROW_LENGTH         = 3'd0,
    CFG_Y_COURANT          = 3'd1,
    CFG_BOUNDARY_ABOVE     = 3'd2,
    CFG_BOUNDARY_SIDE      = 3'd3,
    CFG_INVERSE_ROW_LENGTH = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] cell_value;
    logic [FACTOR_BITS-1:0]       x_courant;
    logic                         frame_start;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] new_value;
    logic signed [VALUE_BITS-1:0] row_average;
    logic                         average_valid;
  } out_word_t;

endpackage

// File: design/upwind_advection_stencil.sv
// an accepted input word is registered in stage 1, stage 2 and stage 3 and then in the output word
// throughput: one word per cycle while out_stall is low, no bubbles; the line buffer reads and writes the
//   same entry at the accept edge, so a one-cell row needs no forwarding
// reset (rst, synchronous, active high) clears the pipeline valids, the column count,
//   the row sum and the left neighbor, sets the first-row flag and loads register defaults;
//   the line buffer itself is not cleared
module upwind_advection_stencil #(
  parameter int LINE_DEPTH = uas_pkg::LINE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  uas_pkg::in_word_t                      in_word,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output uas_pkg::out_word_t                     out_word,
  input  logic                                   cfg_write,
  input  logic [uas_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [uas_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  // widths
  localparam int VB    = uas_pkg::VALUE_BITS;
  localparam int FB    = uas_pkg::FACTOR_BITS;
  localparam int LB    = uas_pkg::LEN_BITS;
  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int LW    = $clog2(LINE_DEPTH + 1);
  localparam int CW    = (LW > LB) ? LW : LB;
  localparam int PW    = VB + FB + 2;          // difference times factor
  localparam int ACC_W = PW + 3;               // three terms plus rounding
  localparam int SHIFT = FB - 1;               // Q1.15 factor scaling
  localparam int SW    = VB + AW + 1;          // row sum
  localparam int MW    = SW + FB + 1;          // row sum times reciprocal

  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-VB+1){1'b1}}, {(VB-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (SHIFT - 1);
  localparam logic signed [MW-1:0]    AVG_MAX = {{(MW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [MW-1:0]    AVG_MIN = {{(MW-VB+1){1'b1}}, {(VB-1){1'b0}}};
  localparam logic signed [MW-1:0]    AVG_RND = MW'(1) <<< (FB - 1);

  // configuration registers
  logic [LB-1:0]          row_length;
  logic [FB-1:0]          y_courant;
  logic signed [VB-1:0]   boundary_above;
  logic signed [VB-1:0]   boundary_side;
  logic [FB-1:0]          inverse_row_length;

  // stream state
  logic [AW-1:0]          column_position;
  logic                   first_row;
  logic signed [VB-1:0]   previous_value;
  logic signed [SW-1:0]   row_sum;

  // line of old values, one entry per column
  logic signed [VB-1:0]   line_mem [LINE_DEPTH];

  // pipeline valids and handshake
  logic s1_valid, s2_valid, s3_valid;
  logic out_open, s3_open, s2_open, s1_open;
  logic accept;

  // stage 1: input word, line read data and neighbor selection flags
  logic signed [VB-1:0]   s1_u;
  logic [FB-1:0]          s1_cx;
  logic signed [VB-1:0]   s1_left;
  logic signed [VB-1:0]   s1_line;
  logic                   s1_first;
  logic                   s1_end;
  logic                   s1_frame;

  // stage 2: products
  logic signed [VB-1:0]   s2_u;
  logic signed [PW-1:0]   s2_px;
  logic signed [PW-1:0]   s2_py;
  logic                   s2_end;
  logic                   s2_frame;

  // stage 3: updated value and row sum including this word
  logic signed [VB-1:0]   s3_nv;
  logic signed [SW-1:0]   s3_total;
  logic                   s3_end;

  // ---------------------------------------------------------------------------
  // handshake: each stage takes a word when it is empty or its word moves on
  // ---------------------------------------------------------------------------
  assign out_open = !out_valid || !out_stall;
  assign s3_open  = !s3_valid || out_open;
  assign s2_open  = !s2_valid || s3_open;
  assign s1_open  = !s1_valid || s2_open;
  assign in_stall = !s1_open;
  assign accept   = in_valid && s1_open;

  // ---------------------------------------------------------------------------
  // accept side: column tracking, row end detection, left neighbor
  // ---------------------------------------------------------------------------
  logic [AW-1:0]        col;
  logic [CW-1:0]        len_ext;
  logic [CW-1:0]        len_eff;
  logic [CW-1:0]        col_inc;
  logic                 row_end;
  logic                 first_now;
  logic signed [VB-1:0] left;

  always_comb begin
    col       = in_word.frame_start ? '0 : column_position;
    first_now = in_word.frame_start || first_row;
    len_ext   = CW'(row_length);
    // zero length acts as one, anything past the line depth as the full line
    if (len_ext == '0) begin
      len_eff = CW'(1);
    end else if (len_ext > CW'(LINE_DEPTH)) begin
      len_eff = CW'(LINE_DEPTH);
    end else begin
      len_eff = len_ext;
    end
    col_inc = CW'(col) + CW'(1);
    // also ends the row when the column already sits past a shrunk row length
    row_end = (col_inc >= len_eff);
    left    = (col == '0) ? boundary_side : previous_value;
  end

  // line buffer: read old entry and write the new old value on the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_line       <= line_mem[col];
      line_mem[col] <= in_word.cell_value;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 -> 2: neighbor differences and the two Courant products
  // ---------------------------------------------------------------------------
  logic signed [VB-1:0] up;
  logic signed [VB:0]   du;
  logic signed [VB:0]   dl;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;

  always_comb begin
    up = s1_first ? boundary_above : s1_line;
    du = (VB+1)'(s1_u) - (VB+1)'(up);
    dl = (VB+1)'(s1_u) - (VB+1)'(s1_left);
    px = PW'(du) * PW'($signed({1'b0, s1_cx}));
    py = PW'(dl) * PW'($signed({1'b0, y_courant}));
  end

  // ---------------------------------------------------------------------------
  // stage 2 -> 3: combine, round half up, saturate, accumulate row sum
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [VB-1:0]    nv;
  logic signed [SW-1:0]    sum_base;
  logic signed [SW-1:0]    sum_new;

  always_comb begin
    acc = (ACC_W'(s2_u) <<< SHIFT) - ACC_W'(s2_px) - ACC_W'(s2_py) + ACC_RND;
    acc_sh = acc >>> SHIFT;
    if (acc_sh > ACC_MAX) begin
      nv = ACC_MAX[VB-1:0];
    end else if (acc_sh < ACC_MIN) begin
      nv = ACC_MIN[VB-1:0];
    end else begin
      nv = acc_sh[VB-1:0];
    end
    // a new pass starts the sum from zero
    sum_base = s2_frame ? '0 : row_sum;
    sum_new  = sum_base + SW'(nv);
  end

  // ---------------------------------------------------------------------------
  // stage 3 -> out: row average by multiplying with the reciprocal length
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] avg_prod;
  logic signed [MW-1:0] avg_sh;
  logic signed [VB-1:0] avg;

  always_comb begin
    avg_prod = MW'(s3_total) * MW'($signed({1'b0, inverse_row_length}));
    avg_sh   = (avg_prod + AVG_RND) >>> FB;
    if (!s3_end) begin
      avg = '0;
    end else if (avg_sh > AVG_MAX) begin
      avg = AVG_MAX[VB-1:0];
    end else if (avg_sh < AVG_MIN) begin
      avg = AVG_MIN[VB-1:0];
    end else begin
      avg = avg_sh[VB-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // control state and configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length         <= LB'(uas_pkg::ROW_LENGTH_RESET);
      y_courant          <= '0;
      boundary_above     <= '0;
      boundary_side      <= '0;
      inverse_row_length <= FB'(uas_pkg::INV_LENGTH_RESET);
      column_position    <= '0;
      first_row          <= 1'b1;
      previous_value     <= '0;
      row_sum            <= '0;
      s1_valid           <= 1'b0;
      s2_valid           <= 1'b0;
      s3_valid           <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          uas_pkg::CFG_ROW_LENGTH:         row_length         <= cfg_data[LB-1:0];
          uas_pkg::CFG_Y_COURANT:          y_courant          <= cfg_data[FB-1:0];
          uas_pkg::CFG_BOUNDARY_ABOVE:     boundary_above     <= $signed(cfg_data[VB-1:0]);
          uas_pkg::CFG_BOUNDARY_SIDE:      boundary_side      <= $signed(cfg_data[VB-1:0]);
          uas_pkg::CFG_INVERSE_ROW_LENGTH: inverse_row_length <= cfg_data[FB-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        column_position <= row_end ? '0 : col_inc[AW-1:0];
        first_row       <= row_end ? 1'b0 : first_now;
        previous_value  <= in_word.cell_value;
      end

      // row sum follows the words in order as they leave stage 2
      if (s2_valid && s3_open) begin
        row_sum <= s2_end ? '0 : sum_new;
      end

      if (s1_open) begin
        s1_valid <= accept;
      end
      if (s2_open) begin
        s2_valid <= s1_valid;
      end
      if (s3_open) begin
        s3_valid <= s2_valid;
      end
      if (out_open) begin
        out_valid <= s3_valid;
      end
    end
  end

  // pipeline payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_u     <= in_word.cell_value;
      s1_cx    <= in_word.x_courant;
      s1_left  <= left;
      s1_first <= first_now;
      s1_end   <= row_end;
      s1_frame <= in_word.frame_start;
    end
    if (s1_valid && s2_open) begin
      s2_u     <= s1_u;
      s2_px    <= px;
      s2_py    <= py;
      s2_end   <= s1_end;
      s2_frame <= s1_frame;
    end
    if (s2_valid && s3_open) begin
      s3_nv    <= nv;
      s3_total <= sum_new;
      s3_end   <= s2_end;
    end
    if (s3_valid && out_open) begin
      out_word.new_value     <= s3_nv;
      out_word.row_average   <= avg;
      out_word.average_valid <= s3_end;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_row_end_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> column_position == '0)
    else $error("column count did not wrap at row end");

  a_frame_sets_first: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.frame_start && !row_end |=> first_row)
    else $error("frame start did not mark the first row");

  a_avg_zero_off_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.average_valid |-> out_word.row_average == '0)
    else $error("row average nonzero on a word that does not end a row");

  a_s1_holds_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_open |=> s1_valid && $stable(s1_u) && $stable(s1_line))
    else $error("stage 1 word lost while downstream was blocked");

endmodule
